>>> hw/rtl/xcpd_pkg.sv
package xcpd_pkg;

    localparam int PACKET_BYTES = 13;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 6;
    localparam int BUF_AW = $clog2(PACKET_BYTES);
    localparam int CNT_W  = $clog2(PACKET_BYTES + 1);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [BUF_AW-1:0] LAST_IDX  = BUF_AW'(PACKET_BYTES - 1);
    localparam logic [CNT_W-1:0]  LAST_FILL = CNT_W'(PACKET_BYTES - 1);

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hFF;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_FAIL = 1'b1;

    localparam logic REG_START_BYTE = 1'b0;

endpackage

>>> hw/rtl/xcpd_ram.sv
module xcpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/xor_checked_packet_deframer_top.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_rx_byte
// output    out        o_valid / i_stall  o_kind, o_packet_byte, o_byte_position, o_last
// config    in         APB write/read     start_byte at byte address 0
//
// A byte that does not complete a packet leaves the block idle, ready for the next byte.
// A packet that passes the check is presented byte by byte: read, load and present
// run in turn for each byte, and an output stall holds the present step.
// A failed packet first presents its failure event, then searches the buffer for the
// next start byte and moves the bytes from it to the front; a stall holds the event.
// Synchronous active-low reset; the buffer needs no clearing pass.
// o_stall is high while an item is being processed, including while a result waits.
module xor_checked_packet_deframer_top
    import xcpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,

    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_kind,
    output logic [BYTE_W-1:0] o_packet_byte,
    output logic [POS_W-1:0]  o_byte_position,
    output logic              o_last,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_OUT,
        ST_FAIL_OUT,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR
    } t_state;

    t_state            r_state, n_state;
    logic [BYTE_W-1:0] r_start_byte;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic [BUF_AW-1:0] r_idx, n_idx;
    logic [BUF_AW-1:0] r_dst, n_dst;

    logic              r_out_valid, n_out_valid;
    logic              r_out_kind, n_out_kind;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic [POS_W-1:0]  r_out_pos, n_out_pos;
    logic              r_out_last, n_out_last;

    logic              ram_we;
    logic [BUF_AW-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [BUF_AW-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic              in_xfer;
    logic              out_xfer;
    logic              cfg_wr;
    logic [BYTE_W-1:0] acc_xor;

    assign in_xfer  = i_valid && (r_state == ST_IDLE);
    assign out_xfer = r_out_valid && !i_stall;
    assign cfg_wr   = psel && penable && pwrite && (paddr[APB_AW-1] == REG_START_BYTE);
    assign acc_xor  = r_xor ^ i_rx_byte;

    xcpd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PACKET_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_xor       = r_xor;
        n_idx       = r_idx;
        n_dst       = r_dst;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_waddr   = r_fill[BUF_AW-1:0];
        ram_wdata   = i_rx_byte;
        ram_re      = 1'b0;
        ram_raddr   = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && !((r_fill == '0) && (i_rx_byte != r_start_byte))) begin
                    ram_we = 1'b1;
                    n_xor  = acc_xor;
                    n_fill = r_fill + CNT_W'(1);
                    if (r_fill == LAST_FILL) begin
                        if (acc_xor == '0) begin
                            n_idx   = '0;
                            n_state = ST_EMIT_RD;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_FAIL;
                            n_out_byte  = '0;
                            n_out_pos   = '0;
                            n_out_last  = 1'b1;
                            n_state     = ST_FAIL_OUT;
                        end
                    end
                end
            end
            ST_EMIT_RD: begin
                ram_re  = 1'b1;
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_DATA;
                n_out_byte  = ram_rdata;
                n_out_pos   = POS_W'(r_idx);
                n_out_last  = (r_idx == LAST_IDX);
                n_state     = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (out_xfer) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_fill  = '0;
                        n_xor   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + BUF_AW'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            ST_FAIL_OUT: begin
                if (out_xfer) begin
                    n_out_valid = 1'b0;
                    n_idx       = BUF_AW'(1);
                    n_state     = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD: begin
                ram_re  = 1'b1;
                n_state = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                if (ram_rdata == r_start_byte) begin
                    n_dst   = '0;
                    n_xor   = '0;
                    n_state = ST_SHIFT_RD;
                end else if (r_idx == LAST_IDX) begin
                    n_fill  = '0;
                    n_xor   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = r_idx + BUF_AW'(1);
                    n_state = ST_SRCH_RD;
                end
            end
            ST_SHIFT_RD: begin
                ram_re  = 1'b1;
                n_state = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_dst;
                ram_wdata = ram_rdata;
                n_xor     = r_xor ^ ram_rdata;
                if (r_idx == LAST_IDX) begin
                    n_fill  = CNT_W'(r_dst) + CNT_W'(1);
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = r_idx + BUF_AW'(1);
                    n_dst   = r_dst + BUF_AW'(1);
                    n_state = ST_SHIFT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_start_byte <= START_BYTE_RST;
            r_fill       <= '0;
            r_xor        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_xor       <= n_xor;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_start_byte <= pwdata[BYTE_W-1:0];
            end
        end
        r_idx      <= n_idx;
        r_dst      <= n_dst;
        r_out_kind <= n_out_kind;
        r_out_byte <= n_out_byte;
        r_out_pos  <= n_out_pos;
        r_out_last <= n_out_last;
    end

    assign o_stall         = (r_state != ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_packet_byte   = r_out_byte;
    assign o_byte_position = r_out_pos;
    assign o_last          = r_out_last;

    assign prdata = {{(APB_DW - BYTE_W){1'b0}}, r_start_byte};
    assign pready = 1'b1;

endmodule

>>> hw/rtl/xcpd_checker.sv
module xcpd_checker
    import xcpd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic              o_kind,
    input logic [BYTE_W-1:0] o_packet_byte,
    input logic [POS_W-1:0]  o_byte_position,
    input logic              o_last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_packet_byte)
            && $stable(o_byte_position) && $stable(o_last))
        else $error("stalled result changed");

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while a result is pending");

    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_FAIL) |-> o_last && (o_packet_byte == '0)
            && (o_byte_position == '0))
        else $error("malformed failure event");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_DATA) |->
            (o_last == (o_byte_position == POS_W'(PACKET_BYTES - 1))))
        else $error("last flag does not match final packet position");

endmodule

bind xor_checked_packet_deframer_top xcpd_checker u_xcpd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_kind          (o_kind),
    .o_packet_byte   (o_packet_byte),
    .o_byte_position (o_byte_position),
    .o_last          (o_last)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench
    import xcpd_pkg::*;
();

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_result;

    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_FAIL
    } t_exp_mode;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_exp_mode         mode;
    } t_dir_row;

    localparam int DIR_ROWS = 30;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 35;
    localparam logic [APB_AW-1:0] START_BYTE_ADDR = APB_AW'(4 * int'(REG_START_BYTE));

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [BYTE_W-1:0] i_rx_byte;
    logic              o_valid;
    logic              i_stall;
    logic              o_kind;
    logic [BYTE_W-1:0] o_packet_byte;
    logic [POS_W-1:0]  o_byte_position;
    logic              o_last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic [BYTE_W-1:0] frame_q [PACKET_BYTES];
    int unsigned       frame_fill;
    logic [BYTE_W-1:0] frame_xor;
    logic [BYTE_W-1:0] start_cfg;

    t_result fresh_results [$];
    t_result results_due [$];
    int      mismatches;
    bit      idle_on;

    t_dir_row directed_rows [DIR_ROWS] = '{
        '{8'h00, EXP_NONE}, '{8'h7E, EXP_NONE},
        '{8'hFF, EXP_MODEL}, '{8'hFF, EXP_MODEL}, '{8'h01, EXP_MODEL}, '{8'h02, EXP_MODEL},
        '{8'h04, EXP_MODEL}, '{8'h08, EXP_MODEL}, '{8'h10, EXP_MODEL}, '{8'h20, EXP_MODEL},
        '{8'h40, EXP_MODEL}, '{8'h80, EXP_MODEL}, '{8'h00, EXP_MODEL}, '{8'h5A, EXP_MODEL},
        '{8'h3C, EXP_FAIL},
        '{8'h66, EXP_MODEL},
        '{8'hFF, EXP_MODEL}, '{8'h00, EXP_MODEL}, '{8'h11, EXP_MODEL}, '{8'h22, EXP_MODEL},
        '{8'h33, EXP_MODEL}, '{8'h44, EXP_MODEL}, '{8'h55, EXP_MODEL}, '{8'h66, EXP_MODEL},
        '{8'h77, EXP_MODEL}, '{8'h88, EXP_MODEL}, '{8'h99, EXP_MODEL}, '{8'hAA, EXP_MODEL},
        '{8'h01, EXP_FAIL},
        '{8'h12, EXP_NONE}
    };

    xor_checked_packet_deframer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_packet_byte   (o_packet_byte),
        .o_byte_position (o_byte_position),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic void clear_frame();
        foreach (frame_q[i]) frame_q[i] = '0;
        frame_fill = 0;
        frame_xor  = '0;
    endfunction

    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        int found;
        fresh_results.delete();
        if (frame_fill >= PACKET_BYTES) clear_frame();
        if (frame_fill == 0 && b != start_cfg) return;
        frame_q[frame_fill] = b;
        frame_xor = frame_xor ^ b;
        frame_fill++;
        if (frame_fill < PACKET_BYTES) return;
        if (frame_xor == '0) begin
            for (int i = 0; i < PACKET_BYTES; i++) begin
                fresh_results.push_back(t_result'{KIND_DATA, frame_q[i], POS_W'(i),
                                                  i == PACKET_BYTES - 1});
            end
            frame_fill = 0;
            frame_xor  = '0;
            return;
        end
        fresh_results.push_back(t_result'{KIND_FAIL, '0, '0, 1'b1});
        found = PACKET_BYTES;
        for (int i = 1; i < PACKET_BYTES; i++) begin
            if (frame_q[i] == start_cfg && found == PACKET_BYTES) found = i;
        end
        if (found < PACKET_BYTES) begin
            frame_xor = '0;
            for (int i = found; i < PACKET_BYTES; i++) begin
                frame_q[i - found] = frame_q[i];
                frame_xor = frame_xor ^ frame_q[i];
            end
            frame_fill = PACKET_BYTES - found;
        end else begin
            clear_frame();
        end
    endfunction

    function automatic logic [BYTE_W-1:0] next_random_byte();
        if (frame_fill == 0) begin
            return ($urandom_range(0, 99) < 85) ? start_cfg : BYTE_W'($urandom);
        end
        if (frame_fill == PACKET_BYTES - 1 && $urandom_range(0, 99) < 60) return frame_xor;
        if ($urandom_range(0, 99) < 8) return start_cfg;
        return BYTE_W'($urandom);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 9) < 3) begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic settle();
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [BYTE_W-1:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= START_BYTE_ADDR;
        pwdata  <= APB_DW'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(input logic [BYTE_W-1:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= START_BYTE_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DW'(v)) begin
            $error("start_byte readback: expected %0h, got %0h", v, prdata);
            mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input logic [BYTE_W-1:0] cfg, input int items);
        int                stored_items;
        logic [BYTE_W-1:0] b;
        logic              stored;
        settle();
        apb_write(cfg);
        apb_check(cfg);
        start_cfg = cfg;
        stored_items = 0;
        while (stored_items < items) begin
            b = next_random_byte();
            stored = (frame_fill != 0) || (b == start_cfg);
            send_byte(b);
            deframe_byte(b);
            foreach (fresh_results[k]) results_due.push_back(fresh_results[k]);
            if (stored) stored_items++;
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        t_result due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                $error("unexpected result transfer: kind %0d byte %0h pos %0d last %0d",
                       o_kind, o_packet_byte, o_byte_position, o_last);
                mismatches++;
            end else begin
                due = results_due.pop_front();
                if (o_kind !== due.kind) begin
                    $error("kind: expected %0d, got %0d", due.kind, o_kind);
                    mismatches++;
                end
                if (o_packet_byte !== due.data) begin
                    $error("packet_byte: expected %0h, got %0h", due.data, o_packet_byte);
                    mismatches++;
                end
                if (o_byte_position !== due.pos) begin
                    $error("byte_position: expected %0d, got %0d", due.pos, o_byte_position);
                    mismatches++;
                end
                if (o_last !== due.last) begin
                    $error("last: expected %0d, got %0d", due.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin : output_stall
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 5);
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
                repeat ($urandom_range(10, 40)) @(negedge i_clk);
            end
        end
    end

    initial begin
        #1_000_000;
        $display("** xor_checked_packet_deframer_top: FAILED **");
        $finish;
    end

    initial begin : stimulus
        t_dir_row row;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_rx_byte  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        mismatches = 0;
        idle_on    = 1'b1;
        start_cfg  = START_BYTE_RST;
        clear_frame();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            row = directed_rows[r];
            send_byte(row.data);
            deframe_byte(row.data);
            unique case (row.mode)
                EXP_NONE: ;
                EXP_FAIL: results_due.push_back(t_result'{KIND_FAIL, '0, '0, 1'b1});
                default: begin
                    foreach (fresh_results[k]) results_due.push_back(fresh_results[k]);
                end
            endcase
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        run_phase(8'h00, PHASE_ITEMS);
        run_phase(BYTE_W'($urandom), PHASE_ITEMS);
        run_phase(8'hFF, PHASE_ITEMS);
        idle_on = 1'b0;
        run_phase(BYTE_W'($urandom), PHASE_ITEMS);

        settle();
        if (mismatches == 0) begin
            $display("** xor_checked_packet_deframer_top: PASSED **");
        end else begin
            $display("** xor_checked_packet_deframer_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/xcpd_pkg.sv
hw/rtl/xcpd_ram.sv
hw/rtl/xor_checked_packet_deframer_top.sv
hw/rtl/xcpd_checker.sv
bench/testbench.sv
